>>> src/mcdr_pkg.sv
// ----------------------------------------------------------------------------
// mcdr_pkg
// Shared constants and types for the chain detonation reach block.
// ----------------------------------------------------------------------------
package mcdr_pkg;

  localparam int MaxBombsDef  = 64;
  localparam int CoordBitsDef = 16;
  localparam int CountBits    = 7;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_G_RD,
    ST_G_WAIT,
    ST_G_CMP,
    ST_G_MUL,
    ST_G_WR,
    ST_W_INIT,
    ST_W_RD,
    ST_W_WAIT,
    ST_W_SCAN,
    ST_W_DONE,
    ST_OUT
  } mcdr_state_t;

endpackage

>>> src/mcdr_ram.sv
// ----------------------------------------------------------------------------
// mcdr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcdr_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/mcdr_dist.sv
// ----------------------------------------------------------------------------
// mcdr_dist
// Shared distance unit: one squaring multiplier reused over three steps to
// test dx*dx + dy*dy <= r*r.
// ----------------------------------------------------------------------------
module mcdr_dist #(
  parameter int CoordBits = 16
) (
  input  logic                 clk,
  input  logic [1:0]           sel,     // 0: dx, 1: dy, 2: r
  input  logic                 start,
  input  logic [CoordBits-1:0] operand,
  output logic                 hit
);

  localparam int SqBits  = 2 * CoordBits;
  localparam int SumBits = SqBits + 1;

  logic [SqBits-1:0]  sq;
  logic [SumBits-1:0] acc_r;

  assign sq = SqBits'(operand) * SqBits'(operand);

  // accumulate the squared distance, then compare against the squared radius
  always_ff @(posedge clk) begin
    if (start) begin
      unique case (sel)
        2'd0:    acc_r <= SumBits'(sq);
        2'd1:    acc_r <= acc_r + SumBits'(sq);
        default: hit   <= acc_r <= SumBits'(sq);
      endcase
    end
  end

endmodule

>>> src/max_chain_detonation_reach_unit.sv
// ----------------------------------------------------------------------------
// max_chain_detonation_reach_unit
// Largest breadth-first chain reach over a set of circles.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions carry one circle each (in_pos_x, in_pos_y, in_radius).
//   Loading accepts one circle per cycle. A transaction with in_last_item set
//   closes the set; the block then stops taking input until its result is
//   loaded into the output register. Circles beyond MaxBombs are dropped and
//   flag overflow. Graph build: every pair is tested in turn, with a fetch of
//   circle i before each row and a row write after it, on one shared
//   squaring unit. Walk: for each start, each dequeued circle takes a queue
//   read and a row fetch plus a scan over every stored circle, and each start
//   adds an init and a done step. The result is held in an output register
//   until out_stall is low. A synchronous active-low reset empties the set;
//   stores need no clearing.
// ----------------------------------------------------------------------------
module max_chain_detonation_reach_unit
  import mcdr_pkg::*;
#(
  parameter int MaxBombs  = MaxBombsDef,
  parameter int CoordBits = CoordBitsDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          in_pos_x,
  input  logic [15:0]          in_pos_y,
  input  logic [15:0]          in_radius,
  input  logic                 in_last_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CountBits-1:0] out_max_reached,
  output logic                 out_overflow
);

  localparam int IdxBits = $clog2(MaxBombs);
  localparam int CntBits = $clog2(MaxBombs + 1);

  mcdr_state_t state_r, state_nxt;

  logic [CntBits-1:0] n_r, n_nxt;
  logic               ovf_r, ovf_nxt;
  logic [IdxBits-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [1:0]         step_r, step_nxt;
  logic [MaxBombs-1:0] row_r, row_nxt;
  logic [MaxBombs-1:0] vis_r, vis_nxt;
  logic [CntBits-1:0] head_r, head_nxt, tail_r, tail_nxt, cnt_r, cnt_nxt;
  logic [CntBits-1:0] best_r, best_nxt;
  logic [IdxBits-1:0] k_r, k_nxt, f_r, f_nxt;
  logic [MaxBombs-1:0] frow_r, frow_nxt;
  logic [CountBits-1:0] res_r, res_nxt;
  logic               resov_r, resov_nxt, ov_r, ov_nxt;

  logic                 in_acc;
  logic                 st_we;
  logic [IdxBits-1:0]   st_wa, st_ra;
  logic [CoordBits-1:0] xi, yi, ri, xr, yr, rr;
  logic                 rw_we, q_we;
  logic [IdxBits-1:0]   rw_wa, rw_ra, q_wa, q_ra;
  logic [MaxBombs-1:0]  rw_wd, rw_rd;
  logic [IdxBits-1:0]   q_wd, q_rd;
  logic [1:0]           d_sel;
  logic                 d_start, d_hit;
  logic [CoordBits-1:0] d_op, xa_r, ya_r, ra_r, xa_nxt, ya_nxt, ra_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_LOAD);
  assign out_valid       = ov_r;
  assign out_max_reached = res_r;
  assign out_overflow    = resov_r;

  // circle store
  assign xi = CoordBits'(in_pos_x);
  assign yi = CoordBits'(in_pos_y);
  assign ri = CoordBits'(in_radius);
  mcdr_ram #(.Width(CoordBits), .Depth(MaxBombs)) u_x (
    .clk, .wr_en(st_we), .wr_addr(st_wa), .wr_data(xi), .rd_addr(st_ra), .rd_data(xr));
  mcdr_ram #(.Width(CoordBits), .Depth(MaxBombs)) u_y (
    .clk, .wr_en(st_we), .wr_addr(st_wa), .wr_data(yi), .rd_addr(st_ra), .rd_data(yr));
  mcdr_ram #(.Width(CoordBits), .Depth(MaxBombs)) u_r (
    .clk, .wr_en(st_we), .wr_addr(st_wa), .wr_data(ri), .rd_addr(st_ra), .rd_data(rr));
  mcdr_ram #(.Width(MaxBombs), .Depth(MaxBombs)) u_rows (
    .clk, .wr_en(rw_we), .wr_addr(rw_wa), .wr_data(rw_wd), .rd_addr(rw_ra), .rd_data(rw_rd));
  mcdr_ram #(.Width(IdxBits), .Depth(MaxBombs)) u_q (
    .clk, .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd), .rd_addr(q_ra), .rd_data(q_rd));

  mcdr_dist #(.CoordBits(CoordBits)) u_dist (
    .clk, .sel(d_sel), .start(d_start), .operand(d_op), .hit(d_hit));

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      n_r     <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
      best_r  <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
      best_r  <= best_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; step_r <= step_nxt; row_r <= row_nxt;
    vis_r <= vis_nxt; head_r <= head_nxt; tail_r <= tail_nxt; cnt_r <= cnt_nxt;
    k_r <= k_nxt; f_r <= f_nxt; frow_r <= frow_nxt; res_r <= res_nxt;
    resov_r <= resov_nxt; xa_r <= xa_nxt; ya_r <= ya_nxt; ra_r <= ra_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; ovf_nxt = ovf_r; ov_nxt = ov_r; best_nxt = best_r;
    i_nxt = i_r; j_nxt = j_r; step_nxt = step_r; row_nxt = row_r;
    vis_nxt = vis_r; head_nxt = head_r; tail_nxt = tail_r; cnt_nxt = cnt_r;
    k_nxt = k_r; f_nxt = f_r; frow_nxt = frow_r; res_nxt = res_r;
    resov_nxt = resov_r; xa_nxt = xa_r; ya_nxt = ya_r; ra_nxt = ra_r;
    // keep circle i, then circle j, on the read port while its fields are in use
    st_we = 1'b0; st_wa = n_r[IdxBits-1:0];
    st_ra = (step_r == 2'd0) ? i_r : j_r;
    rw_we = 1'b0; rw_wa = i_r; rw_wd = row_r; rw_ra = f_r;
    q_we = 1'b0; q_wa = tail_r[IdxBits-1:0]; q_wd = i_r;
    q_ra = head_r[IdxBits-1:0];
    d_sel = 2'd0; d_start = 1'b0; d_op = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (n_r < CntBits'(MaxBombs)) begin
            st_we = 1'b1;
            n_nxt = n_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_item) begin
            i_nxt = '0; j_nxt = '0; row_nxt = '0; step_nxt = 2'd0;
            state_nxt = ST_G_RD;
          end
        end
      end
      // fetch circle i, latch it, then stream circle j
      ST_G_RD: begin
        st_ra = (step_r == 2'd0) ? i_r : j_r;
        state_nxt = ST_G_WAIT;
      end
      ST_G_WAIT: begin
        if (step_r == 2'd0) begin
          xa_nxt = xr; ya_nxt = yr; ra_nxt = rr;
          step_nxt = 2'd1;
          state_nxt = ST_G_RD;
        end else begin
          state_nxt = ST_G_CMP;
        end
      end
      ST_G_CMP: begin
        d_start = 1'b1;
        if (step_r == 2'd1) begin
          d_sel = 2'd0; d_op = (xa_r >= xr) ? xa_r - xr : xr - xa_r;
          step_nxt = 2'd2;
        end else if (step_r == 2'd2) begin
          d_sel = 2'd1; d_op = (ya_r >= yr) ? ya_r - yr : yr - ya_r;
          step_nxt = 2'd3;
        end else begin
          d_sel = 2'd2; d_op = ra_r;
          state_nxt = ST_G_MUL;
        end
      end
      ST_G_MUL: begin
        row_nxt[j_r] = d_hit && (j_r != i_r);
        step_nxt = 2'd1;
        if ({1'b0, j_r} + 1'b1 >= n_r) begin
          state_nxt = ST_G_WR;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = ST_G_RD;
        end
      end
      ST_G_WR: begin
        rw_we = 1'b1;
        row_nxt = '0; j_nxt = '0; step_nxt = 2'd0;
        if ({1'b0, i_r} + 1'b1 >= n_r) begin
          i_nxt = '0; best_nxt = '0;
          state_nxt = ST_W_INIT;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = ST_G_RD;
        end
      end
      // breadth-first walk from start i
      ST_W_INIT: begin
        vis_nxt = '0; vis_nxt[i_r] = 1'b1;
        q_we = 1'b1; q_wa = '0; q_wd = i_r;
        head_nxt = '0; tail_nxt = CntBits'(1); cnt_nxt = CntBits'(1);
        state_nxt = ST_W_RD;
      end
      ST_W_RD: begin
        if (head_r < tail_r) begin
          head_nxt = head_r + 1'b1;
          state_nxt = ST_W_WAIT;
        end else begin
          state_nxt = ST_W_DONE;
        end
      end
      ST_W_WAIT: begin
        rw_ra = q_rd;
        f_nxt = q_rd;
        k_nxt = '0;
        state_nxt = ST_W_SCAN;
      end
      ST_W_SCAN: begin
        if (k_r == '0) frow_nxt = rw_rd;
        if ((k_r == '0 ? rw_rd[k_r] : frow_r[k_r]) && !vis_r[k_r]) begin
          vis_nxt[k_r] = 1'b1;
          q_we = 1'b1; q_wd = k_r;
          tail_nxt = tail_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
        if ({1'b0, k_r} + 1'b1 >= n_r) begin
          state_nxt = ST_W_RD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_W_DONE: begin
        if (cnt_r > best_r) best_nxt = cnt_r;
        if ({1'b0, i_r} + 1'b1 >= n_r) begin
          state_nxt = ST_OUT;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = ST_W_INIT;
        end
      end
      ST_OUT: begin
        if (!ov_r) begin
          res_nxt = CountBits'(best_r);
          resov_nxt = ovf_r;
          ov_nxt = 1'b1;
          n_nxt = '0; ovf_nxt = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
    // an empty set still gives a result of zero
    if (state_r == ST_LOAD && in_acc && in_last_item && n_nxt == '0) begin
      best_nxt = '0;
      state_nxt = ST_OUT;
    end
  end

endmodule

>>> src/mcdr_checker.sv
// ----------------------------------------------------------------------------
// mcdr_checker
// Port-level checks for the chain detonation reach block.
// ----------------------------------------------------------------------------
module mcdr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last_item,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_max_reached
);

  // a closing transaction blocks further input
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_item |=> in_stall) else $error("no stall after last");

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_max_reached))
    else $error("result dropped");

  // result never exceeds capacity
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_max_reached <= 7'd64) else $error("count out of range");

endmodule

bind max_chain_detonation_reach_unit mcdr_checker u_mcdr_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_last_item, .out_valid, .out_stall,
  .out_max_reached);
